### design/clq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clq_pkg
// Shared types and codes for the circular linked queue manager.
// ----------------------------------------------------------------------------
package clq_pkg;

	localparam int CMD_W   = 1;
	localparam int QID_W   = 2;
	localparam int EID_W   = 6;
	localparam int ST_W    = 3;
	localparam int QCNT_W  = 7;

	localparam logic [CMD_W-1:0] CMD_APPEND = 1'b0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_QUEUED   = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [ST_W-1:0] ST_UNQUEUED = 3'd3;
	localparam logic [ST_W-1:0] ST_OTHER_Q  = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [QID_W-1:0] queue_id;
		logic [EID_W-1:0] elem_id;
	} clq_req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic              head_valid;
		logic [EID_W-1:0]  head_elem;
		logic [QCNT_W-1:0] queue_count;
	} clq_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic clear;   // reset sweep of tag and queue memories
		logic load;    // capture request, read tag and queue state
		logic lookup;  // first link pass (reads, append head links)
		logic in_link; // controller sits in the second link pass
		logic commit;  // final writes and result capture
	} clq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic need_link;
	} clq_sts_t;

endpackage

### design/clq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clq_ctrl
// Sequencer for the queue manager: reset sweep, lookup, link update and
// result handoff.
// ----------------------------------------------------------------------------
module clq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  clq_pkg::clq_sts_t sts,
	output clq_pkg::clq_cmd_t cmd
);

	localparam logic [1:0] S_CLEAR  = 2'd0;
	localparam logic [1:0] S_IDLE   = 2'd1;
	localparam logic [1:0] S_LOOKUP = 2'd2;
	localparam logic [1:0] S_LINK   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.clear   = (state_q == S_CLEAR);
		cmd.load    = accept;
		cmd.lookup  = (state_q == S_LOOKUP) && sts.need_link;
		cmd.in_link = (state_q == S_LINK);
		cmd.commit  = ((state_q == S_LOOKUP) && !sts.need_link && out_free) ||
		              ((state_q == S_LINK) && out_free);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				if (sts.need_link) state_d = S_LINK;
				else if (out_free) state_d = S_IDLE;
			end
			S_LINK: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold the result until the transaction completes
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

### design/clq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clq_datapath
// Link, tag and queue-state memories with the update logic of the queue
// manager.
// ----------------------------------------------------------------------------
module clq_datapath #(
	parameter int NUM_ELEMS  = 64,
	parameter int NUM_QUEUES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  clq_pkg::clq_req_t req,
	input  clq_pkg::clq_cmd_t cmd,
	output clq_pkg::clq_sts_t sts,
	output clq_pkg::clq_rsp_t rsp
);

	localparam int EW     = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;
	localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int CW     = $clog2(NUM_ELEMS + 1);
	localparam int CLR_N  = (NUM_ELEMS > NUM_QUEUES) ? NUM_ELEMS : NUM_QUEUES;
	localparam int CLR_W  = $clog2(CLR_N + 1);
	localparam int TAG_W  = QW + 1;
	localparam int QS_W   = EW + CW;
	localparam int EID_N  = 1 << clq_pkg::EID_W;
	localparam int QID_N  = 1 << clq_pkg::QID_W;

	// index folding tables (field modulo pool size)
	logic [EW-1:0] elem_map [EID_N];
	logic [QW-1:0] queue_map [QID_N];

	for (genvar i = 0; i < EID_N; i++) begin : g_emap
		assign elem_map[i] = EW'(i % NUM_ELEMS);
	end
	for (genvar i = 0; i < QID_N; i++) begin : g_qmap
		assign queue_map[i] = QW'(i % NUM_QUEUES);
	end

	logic [EW-1:0]    next_mem [NUM_ELEMS];
	logic [EW-1:0]    prev_mem [NUM_ELEMS];
	logic [TAG_W-1:0] tag_mem  [NUM_ELEMS];
	logic [QS_W-1:0]  qs_mem   [NUM_QUEUES];

	logic [CLR_W-1:0]              clr_cnt_q;
	logic [clq_pkg::CMD_W-1:0]     cmd_q;
	logic [QW-1:0]                 q_q;
	logic [EW-1:0]                 e_q;
	logic [TAG_W-1:0]              tag_rd_q;
	logic [QS_W-1:0]               qs_rd_q;
	logic [EW-1:0]                 nx_rd_q;
	logic [EW-1:0]                 pv_rd_q;
	clq_pkg::clq_rsp_t             rsp_q;

	logic                  is_append;
	logic                  queued;
	logic [QW-1:0]         owner;
	logic [EW-1:0]         head;
	logic [CW-1:0]         cnt;
	logic [clq_pkg::ST_W-1:0] status;
	logic                  ok;
	logic [EW-1:0]         head_new;
	logic [CW-1:0]         cnt_new;
	logic                  head_valid;
	logic [EW+clq_pkg::EID_W-1:0]  head_ext;
	logic [CW+clq_pkg::QCNT_W-1:0] cnt_ext;

	assign is_append = (cmd_q == clq_pkg::CMD_APPEND);
	assign queued    = tag_rd_q[QW];
	assign owner     = tag_rd_q[QW-1:0];
	assign head      = qs_rd_q[QS_W-1:CW];
	assign cnt       = qs_rd_q[CW-1:0];

	always_comb begin
		case (cmd_q)
			clq_pkg::CMD_APPEND: begin
				status = queued ? clq_pkg::ST_QUEUED : clq_pkg::ST_OK;
			end
			default: begin
				if (cnt == '0) status = clq_pkg::ST_EMPTY;
				else if (!queued) status = clq_pkg::ST_UNQUEUED;
				else if (owner != q_q) status = clq_pkg::ST_OTHER_Q;
				else status = clq_pkg::ST_OK;
			end
		endcase
	end

	assign ok = (status == clq_pkg::ST_OK);

	always_comb begin
		head_new = head;
		cnt_new  = cnt;
		if (ok) begin
			if (is_append) begin
				head_new = (cnt == '0) ? e_q : head;
				cnt_new  = cnt + CW'(1);
			end else if (cnt == CW'(1)) begin
				head_new = '0;
				cnt_new  = '0;
			end else begin
				// removing the head moves it to its successor
				head_new = (head == e_q) ? nx_rd_q : head;
				cnt_new  = cnt - CW'(1);
			end
		end
	end

	assign head_valid = (cnt_new != '0);
	assign head_ext   = {{clq_pkg::EID_W{1'b0}}, head_new};
	assign cnt_ext    = {{clq_pkg::QCNT_W{1'b0}}, cnt_new};

	assign sts.need_link  = ok && (is_append ? (cnt != '0) : (cnt != '0 && cnt != CW'(1)));
	assign sts.clear_done = (clr_cnt_q == CLR_W'(CLR_N - 1));

	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear && !sts.clear_done) begin
			clr_cnt_q <= clr_cnt_q + CLR_W'(1);
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= req.command;
			q_q   <= queue_map[req.queue_id];
			e_q   <= elem_map[req.elem_id];
		end
	end

	// tag memory: queued flag and owning queue
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			if (clr_cnt_q < CLR_W'(NUM_ELEMS)) tag_mem[clr_cnt_q[EW-1:0]] <= '0;
		end else if (cmd.commit && ok) begin
			tag_mem[e_q] <= {is_append, q_q};
		end
		if (cmd.load) tag_rd_q <= tag_mem[elem_map[req.elem_id]];
	end

	// queue state memory: head and count
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			if (clr_cnt_q < CLR_W'(NUM_QUEUES)) qs_mem[clr_cnt_q[QW-1:0]] <= '0;
		end else if (cmd.commit && ok) begin
			qs_mem[q_q] <= {head_new, cnt_new};
		end
		if (cmd.load) qs_rd_q <= qs_mem[queue_map[req.queue_id]];
	end

	// forward links
	always_ff @(posedge clk) begin
		if (cmd.lookup && is_append) begin
			next_mem[e_q] <= head;
		end else if (cmd.commit && ok && !cmd.in_link && is_append) begin
			next_mem[e_q] <= e_q;
		end else if (cmd.commit && cmd.in_link) begin
			// append: old tail points at new element; remove: bridge the gap
			if (is_append) next_mem[pv_rd_q] <= e_q;
			else next_mem[pv_rd_q] <= nx_rd_q;
		end
		if (cmd.lookup) nx_rd_q <= next_mem[e_q];
	end

	// backward links
	always_ff @(posedge clk) begin
		if (cmd.lookup && is_append) begin
			prev_mem[head] <= e_q;
		end else if (cmd.commit && ok && !cmd.in_link && is_append) begin
			prev_mem[e_q] <= e_q;
		end else if (cmd.commit && cmd.in_link) begin
			if (is_append) prev_mem[e_q] <= pv_rd_q;
			else prev_mem[nx_rd_q] <= pv_rd_q;
		end
		// append reads the old tail before the head link is rewritten
		if (cmd.lookup) pv_rd_q <= prev_mem[is_append ? head : e_q];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status      <= status;
			rsp_q.head_valid  <= head_valid;
			rsp_q.head_elem   <= head_valid ? head_ext[clq_pkg::EID_W-1:0] : '0;
			rsp_q.queue_count <= cnt_ext[clq_pkg::QCNT_W-1:0];
		end
	end

endmodule

### design/circular_linked_queue_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_linked_queue_manager
// Circular doubly linked queues over a shared pool of element slots.
// ----------------------------------------------------------------------------
// Each request appends an element at a queue's tail or removes it from
// anywhere in its queue, and returns one result with the status, the queue's
// head and its element count afterwards. One request is handled at a time.
// Errors, an append to an empty queue and the removal of a queue's last
// element reach the result register in the lookup step; other appends and
// removals pass through the link step after it and reach the result register
// there, as the two passes over the single-port link memories require (read
// the neighbor links, then rewrite them).
// After reset a clearing sweep over max(NUM_ELEMS, NUM_QUEUES) entries
// empties the element tags and queue states; requests are stalled until it
// ends. A finished result waits in the output register while the next
// request is accepted; that request then holds its final step until the
// waiting result is taken.
// ----------------------------------------------------------------------------
module circular_linked_queue_manager #(
	parameter int NUM_ELEMS  = 64,
	parameter int NUM_QUEUES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  clq_pkg::clq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output clq_pkg::clq_rsp_t rsp
);

	clq_pkg::clq_cmd_t cmd;
	clq_pkg::clq_sts_t sts;

	clq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	clq_datapath #(
		.NUM_ELEMS  (NUM_ELEMS),
		.NUM_QUEUES (NUM_QUEUES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
